@@ hdl/i2cms_pkg.sv @@
// i2cms_pkg: shared types, command codes and line phase table for the
// I2C master line sequencer. Depends on nothing; used by every module in hdl.
package i2cms_pkg;

  // command codes carried in req_type
  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_STOP  = 3'd1;
  localparam logic [2:0] REQ_ACK   = 3'd2;
  localparam logic [2:0] REQ_NACK  = 3'd3;
  localparam logic [2:0] REQ_WACK  = 3'd4;
  localparam logic [2:0] REQ_WRITE = 3'd5;
  localparam logic [2:0] REQ_READ  = 3'd6;
  localparam logic [2:0] REQ_NONE  = 3'd7;

  // line action codes at the start of a phase
  localparam logic [1:0] LN_LOW  = 2'd0;
  localparam logic [1:0] LN_HIGH = 2'd1;
  localparam logic [1:0] LN_BIT  = 2'd2;
  localparam logic [1:0] LN_KEEP = 2'd3;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd360;
  localparam logic [2:0]  LAST_BIT        = 3'd7;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
  } out_item_t;

  typedef struct packed {
    logic [1:0] scl;
    logic [1:0] sda;
  } line_phase_t;

  // number of phases in each command sequence
  function automatic logic [2:0] phase_count(input logic [2:0] cmd);
    logic [2:0] n;
    begin
      unique case (cmd)
        REQ_START, REQ_STOP:         n = 3'd2;
        REQ_ACK:                     n = 3'd5;
        REQ_NACK, REQ_WACK, REQ_READ: n = 3'd3;
        REQ_WRITE:                   n = 3'd4;
        default:                     n = 3'd1;
      endcase
      return n;
    end
  endfunction

  // line actions for one phase of one command
  function automatic line_phase_t phase_entry(input logic [2:0] cmd, input logic [2:0] ph);
    line_phase_t e;
    begin
      e = '{scl: LN_KEEP, sda: LN_KEEP};
      unique case ({cmd, ph})
        {REQ_START, 3'd0}: e = '{scl: LN_HIGH, sda: LN_HIGH};
        {REQ_START, 3'd1}: e = '{scl: LN_KEEP, sda: LN_LOW};
        {REQ_STOP,  3'd0}: e = '{scl: LN_HIGH, sda: LN_LOW};
        {REQ_STOP,  3'd1}: e = '{scl: LN_KEEP, sda: LN_HIGH};
        {REQ_ACK,   3'd0}: e = '{scl: LN_LOW,  sda: LN_HIGH};
        {REQ_ACK,   3'd1}: e = '{scl: LN_KEEP, sda: LN_LOW};
        {REQ_ACK,   3'd2}: e = '{scl: LN_HIGH, sda: LN_KEEP};
        {REQ_ACK,   3'd3}: e = '{scl: LN_LOW,  sda: LN_KEEP};
        {REQ_ACK,   3'd4}: e = '{scl: LN_KEEP, sda: LN_HIGH};
        {REQ_NACK,  3'd0}: e = '{scl: LN_LOW,  sda: LN_HIGH};
        {REQ_NACK,  3'd1}: e = '{scl: LN_HIGH, sda: LN_KEEP};
        {REQ_NACK,  3'd2}: e = '{scl: LN_LOW,  sda: LN_KEEP};
        {REQ_WACK,  3'd0}: e = '{scl: LN_LOW,  sda: LN_HIGH};
        {REQ_WACK,  3'd1}: e = '{scl: LN_HIGH, sda: LN_KEEP};
        {REQ_WACK,  3'd2}: e = '{scl: LN_LOW,  sda: LN_KEEP};
        {REQ_WRITE, 3'd0}: e = '{scl: LN_LOW,  sda: LN_LOW};
        {REQ_WRITE, 3'd1}: e = '{scl: LN_KEEP, sda: LN_BIT};
        {REQ_WRITE, 3'd2}: e = '{scl: LN_HIGH, sda: LN_KEEP};
        {REQ_WRITE, 3'd3}: e = '{scl: LN_LOW,  sda: LN_KEEP};
        {REQ_READ,  3'd0}: e = '{scl: LN_LOW,  sda: LN_KEEP};
        {REQ_READ,  3'd1}: e = '{scl: LN_HIGH, sda: LN_KEEP};
        {REQ_READ,  3'd2}: e = '{scl: LN_LOW,  sda: LN_KEEP};
        default:           e = '{scl: LN_KEEP, sda: LN_KEEP};
      endcase
      return e;
    end
  endfunction

endpackage

@@ hdl/i2cms_seq.sv @@
// i2cms_seq: sequencer state and the one-tick update of the bus lines.
// Depends on i2cms_pkg for item types, command codes and the phase table.
module i2cms_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  i2cms_pkg::in_item_t  item,
  input  logic [15:0]          phase_ticks,
  output i2cms_pkg::out_item_t result
);

  logic [2:0]  command_reg, command_reg_next;
  logic        active, active_next;
  logic [2:0]  phase_index, phase_index_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic        scl_level, scl_level_next;
  logic        sda_level, sda_level_next;
  logic [7:0]  received_byte, received_byte_next;
  logic        ack_flag, ack_flag_next;
  logic        busy, done;
  logic [15:0] tick_inc;
  logic [3:0]  phase_inc;
  i2cms_pkg::line_phase_t entry;

  // next state for one tick
  always_comb begin
    command_reg_next   = command_reg;
    active_next        = active;
    phase_index_next   = phase_index;
    bit_index_next     = bit_index;
    tick_count_next    = tick_count;
    shift_reg_next     = shift_reg;
    scl_level_next     = scl_level;
    sda_level_next     = sda_level;
    received_byte_next = received_byte;
    ack_flag_next      = ack_flag;
    busy               = 1'b0;
    done               = 1'b0;

    // command taken only while idle
    if (!active && item.cmd_valid && item.req_type != i2cms_pkg::REQ_NONE) begin
      active_next      = 1'b1;
      command_reg_next = item.req_type;
      phase_index_next = '0;
      bit_index_next   = '0;
      tick_count_next  = '0;
      shift_reg_next   = (item.req_type == i2cms_pkg::REQ_WRITE) ? item.tx_byte : 8'h00;
    end

    entry     = i2cms_pkg::phase_entry(command_reg_next, phase_index_next);
    tick_inc  = tick_count_next + 16'd1;
    phase_inc = {1'b0, phase_index_next} + 4'd1;

    if (active_next) begin
      busy = 1'b1;

      // line levels change on the first tick of a phase
      if (tick_count_next == '0) begin
        if (entry.scl != i2cms_pkg::LN_KEEP) scl_level_next = entry.scl[0];
        if (entry.sda == i2cms_pkg::LN_BIT) sda_level_next = shift_reg_next[7];
        else if (entry.sda != i2cms_pkg::LN_KEEP) sda_level_next = entry.sda[0];
      end

      tick_count_next = tick_inc;
      if (tick_inc >= phase_ticks) begin
        tick_count_next = '0;
        // sampling and shifting at the end of a phase
        if (command_reg_next == i2cms_pkg::REQ_WACK && phase_index_next == 3'd1)
          ack_flag_next = ~item.sda_in;
        if (command_reg_next == i2cms_pkg::REQ_READ && phase_index_next == 3'd1)
          shift_reg_next = {shift_reg_next[6:0], item.sda_in};
        if (command_reg_next == i2cms_pkg::REQ_WRITE && phase_index_next == 3'd3)
          shift_reg_next = {shift_reg_next[6:0], 1'b0};

        if (phase_inc >= {1'b0, i2cms_pkg::phase_count(command_reg_next)}) begin
          phase_index_next = '0;
          if ((command_reg_next == i2cms_pkg::REQ_WRITE ||
               command_reg_next == i2cms_pkg::REQ_READ) &&
              bit_index_next < i2cms_pkg::LAST_BIT) begin
            bit_index_next = bit_index_next + 3'd1;
          end else begin
            if (command_reg_next == i2cms_pkg::REQ_READ) received_byte_next = shift_reg_next;
            bit_index_next = '0;
            active_next    = 1'b0;
            done           = 1'b1;
          end
        end else begin
          phase_index_next = phase_inc[2:0];
        end
      end
    end
  end

  // state register, advanced once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      command_reg   <= '0;
      active        <= 1'b0;
      phase_index   <= '0;
      bit_index     <= '0;
      tick_count    <= '0;
      shift_reg     <= '0;
      scl_level     <= 1'b1;
      sda_level     <= 1'b1;
      received_byte <= '0;
      ack_flag      <= 1'b0;
    end else if (step) begin
      command_reg   <= command_reg_next;
      active        <= active_next;
      phase_index   <= phase_index_next;
      bit_index     <= bit_index_next;
      tick_count    <= tick_count_next;
      shift_reg     <= shift_reg_next;
      scl_level     <= scl_level_next;
      sda_level     <= sda_level_next;
      received_byte <= received_byte_next;
      ack_flag      <= ack_flag_next;
    end
  end

  // result of this tick
  assign result = '{scl_out: scl_level_next, sda_out: sda_level_next, busy_res: busy,
                    done_res: done, rx_byte: received_byte_next, ack_received: ack_flag_next};

endmodule

@@ hdl/i2cms_skid.sv @@
// i2cms_skid: output register plus one skid entry for result items.
// Depends on i2cms_pkg for the result item type.
module i2cms_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  i2cms_pkg::out_item_t push_data,
  output logic                 push_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cms_pkg::out_item_t out_data
);

  logic                 skid_valid;
  i2cms_pkg::out_item_t skid_data;

  assign push_ready = ~skid_valid;

  // main register refills from the skid first, else from the new result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

@@ hdl/i2c_master_bit_sequencer.sv @@
// i2c_master_bit_sequencer: top level of the I2C master line sequencer.
// Depends on i2cms_pkg, i2cms_seq and i2cms_skid.
//
// Each input transaction is one tick of bus timing and yields exactly one
// registered result transaction. A transaction is taken every clock
// while results drain; the state update is a single pass of logic between
// the sequencer state and the output register, and a one-entry skid stage
// keeps the input open for one more transaction while a result waits.
// Phase lengths count transactions, not clocks: each SCL/SDA phase lasts
// phase_ticks transactions (zero acts as one). phase_ticks is written
// through cfg_wr_en/cfg_wr_data and should change only while no command is
// in progress.
module i2c_master_bit_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cms_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cms_pkg::out_item_t out_data
);

  logic [15:0]          phase_ticks;
  logic                 step;
  i2cms_pkg::out_item_t step_result;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= i2cms_pkg::PHASE_TICKS_RST;
    end else if (cfg_wr_en) begin
      phase_ticks <= cfg_wr_data;
    end
  end

  assign step = in_valid & in_ready;

  // line sequencer
  i2cms_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (in_data),
    .phase_ticks (phase_ticks),
    .result      (step_result)
  );

  // result register and skid stage
  i2cms_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_data  (step_result),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

@@ hdl/i2cms_checker.sv @@
// i2cms_checker: port-level assertions for i2c_master_bit_sequencer.
// Depends on i2cms_pkg; bound to the top level at the end of this file.
module i2cms_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input i2cms_pkg::out_item_t out_data
);

  // input only closes when a result is already waiting
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // after every transaction a result is valid on the next clock
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("transaction gave no result");

  // a finishing tick is always a busy tick
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.done_res) |-> out_data.busy_res)
    else $error("done without busy");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ sim/tb_i2c_master_bit_sequencer.sv @@
// tb_i2c_master_bit_sequencer: self-checking bench for the I2C master line sequencer.
// Depends on i2cms_pkg and i2c_master_bit_sequencer; a local line predictor
// supplies the expected result for every bus tick transaction.
module tb_i2c_master_bit_sequencer;

  localparam int CYCLE_LIMIT = 100000;
  localparam int MAX_REPORTS = 10;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [15:0]          cfg_wr_data = 16'd0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  i2cms_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  i2cms_pkg::out_item_t out_data;

  i2c_master_bit_sequencer DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // clock, period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // bus ticks waiting to be sent and line states waiting to be seen
  i2cms_pkg::in_item_t  pending_ticks[$];
  i2cms_pkg::out_item_t expected_lines[$];

  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int ticks_queued = 0;
  int ticks_taken = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int cmds_issued = 0;
  int cfg_writes = 0;

  // predicted sequencer state
  logic [15:0] phase_len_cfg = i2cms_pkg::PHASE_TICKS_RST;
  logic        seq_running = 1'b0;
  logic [2:0]  seq_cmd = 3'd0;
  logic [2:0]  seq_phase = 3'd0;
  logic [2:0]  seq_bit = 3'd0;
  logic [15:0] seq_ticks = 16'd0;
  logic [7:0]  seq_shift = 8'd0;
  logic        bus_scl = 1'b1;
  logic        bus_sda = 1'b1;
  logic [7:0]  rx_last = 8'd0;
  logic        ack_seen = 1'b0;

  // number of line phases per command (per bit for byte transfers)
  function automatic int phases_in(input logic [2:0] cmd);
    case (cmd)
      i2cms_pkg::REQ_START, i2cms_pkg::REQ_STOP: return 2;
      i2cms_pkg::REQ_ACK:                        return 5;
      i2cms_pkg::REQ_WRITE:                      return 4;
      i2cms_pkg::REQ_NACK, i2cms_pkg::REQ_WACK, i2cms_pkg::REQ_READ: return 3;
      default:                                   return 1;
    endcase
  endfunction

  // line actions at phase start, {scl action, sda action}
  function automatic logic [3:0] bus_phase_action(input logic [2:0] cmd, input logic [2:0] ph);
    case (cmd)
      i2cms_pkg::REQ_START:
        return (ph == 3'd0) ? {i2cms_pkg::LN_HIGH, i2cms_pkg::LN_HIGH}
                            : {i2cms_pkg::LN_KEEP, i2cms_pkg::LN_LOW};
      i2cms_pkg::REQ_STOP:
        return (ph == 3'd0) ? {i2cms_pkg::LN_HIGH, i2cms_pkg::LN_LOW}
                            : {i2cms_pkg::LN_KEEP, i2cms_pkg::LN_HIGH};
      i2cms_pkg::REQ_ACK: begin
        case (ph)
          3'd0:    return {i2cms_pkg::LN_LOW, i2cms_pkg::LN_HIGH};
          3'd1:    return {i2cms_pkg::LN_KEEP, i2cms_pkg::LN_LOW};
          3'd2:    return {i2cms_pkg::LN_HIGH, i2cms_pkg::LN_KEEP};
          3'd3:    return {i2cms_pkg::LN_LOW, i2cms_pkg::LN_KEEP};
          default: return {i2cms_pkg::LN_KEEP, i2cms_pkg::LN_HIGH};
        endcase
      end
      i2cms_pkg::REQ_NACK, i2cms_pkg::REQ_WACK: begin
        case (ph)
          3'd0:    return {i2cms_pkg::LN_LOW, i2cms_pkg::LN_HIGH};
          3'd1:    return {i2cms_pkg::LN_HIGH, i2cms_pkg::LN_KEEP};
          default: return {i2cms_pkg::LN_LOW, i2cms_pkg::LN_KEEP};
        endcase
      end
      i2cms_pkg::REQ_WRITE: begin
        case (ph)
          3'd0:    return {i2cms_pkg::LN_LOW, i2cms_pkg::LN_LOW};
          3'd1:    return {i2cms_pkg::LN_KEEP, i2cms_pkg::LN_BIT};
          3'd2:    return {i2cms_pkg::LN_HIGH, i2cms_pkg::LN_KEEP};
          default: return {i2cms_pkg::LN_LOW, i2cms_pkg::LN_KEEP};
        endcase
      end
      i2cms_pkg::REQ_READ:
        return (ph == 3'd1) ? {i2cms_pkg::LN_HIGH, i2cms_pkg::LN_KEEP}
                            : {i2cms_pkg::LN_LOW, i2cms_pkg::LN_KEEP};
      default: return {i2cms_pkg::LN_KEEP, i2cms_pkg::LN_KEEP};
    endcase
  endfunction

  // advance the predicted sequencer by one bus tick, return the line state
  function automatic i2cms_pkg::out_item_t line_sequencer_tick(input i2cms_pkg::in_item_t t);
    logic [3:0]           act;
    logic                 busy;
    logic                 done;
    i2cms_pkg::out_item_t r;
    busy = 1'b0;
    done = 1'b0;
    if (!seq_running && t.cmd_valid && t.req_type != i2cms_pkg::REQ_NONE) begin
      seq_running = 1'b1;
      seq_cmd = t.req_type;
      seq_phase = 3'd0;
      seq_bit = 3'd0;
      seq_ticks = 16'd0;
      seq_shift = (t.req_type == i2cms_pkg::REQ_WRITE) ? t.tx_byte : 8'h00;
    end
    if (seq_running) begin
      busy = 1'b1;
      act = bus_phase_action(seq_cmd, seq_phase);
      // lines change on the first tick of a phase
      if (seq_ticks == 16'd0) begin
        if (act[3:2] != i2cms_pkg::LN_KEEP) bus_scl = act[2];
        if (act[1:0] == i2cms_pkg::LN_BIT) bus_sda = seq_shift[7];
        else if (act[1:0] != i2cms_pkg::LN_KEEP) bus_sda = act[0];
      end
      seq_ticks = seq_ticks + 16'd1;
      // end of phase: sample, shift, move on
      if (seq_ticks >= phase_len_cfg) begin
        seq_ticks = 16'd0;
        if (seq_cmd == i2cms_pkg::REQ_WACK && seq_phase == 3'd1)
          ack_seen = ~t.sda_in;
        if (seq_cmd == i2cms_pkg::REQ_READ && seq_phase == 3'd1)
          seq_shift = {seq_shift[6:0], t.sda_in};
        if (seq_cmd == i2cms_pkg::REQ_WRITE && seq_phase == 3'd3)
          seq_shift = {seq_shift[6:0], 1'b0};
        if (int'(seq_phase) + 1 >= phases_in(seq_cmd)) begin
          seq_phase = 3'd0;
          if ((seq_cmd == i2cms_pkg::REQ_WRITE || seq_cmd == i2cms_pkg::REQ_READ) &&
              seq_bit != i2cms_pkg::LAST_BIT) begin
            seq_bit = seq_bit + 3'd1;
          end else begin
            if (seq_cmd == i2cms_pkg::REQ_READ) rx_last = seq_shift;
            seq_bit = 3'd0;
            seq_running = 1'b0;
            done = 1'b1;
          end
        end else begin
          seq_phase = seq_phase + 3'd1;
        end
      end
    end
    r.scl_out = bus_scl;
    r.sda_out = bus_sda;
    r.busy_res = busy;
    r.done_res = done;
    r.rx_byte = rx_last;
    r.ack_received = ack_seen;
    return r;
  endfunction

  // one command and all its busy ticks; sda_pat gives the level at each sample
  // point, MSB first; busy ticks may carry commands that must be ignored
  task automatic push_command(input logic [2:0] req, input logic [7:0] txb,
                              input logic [7:0] sda_pat, input int noise_pct);
    i2cms_pkg::in_item_t t;
    int eff;
    int span;
    int per_bit;
    int s;
    eff = (phase_len_cfg == 16'd0) ? 1 : int'(phase_len_cfg);
    per_bit = phases_in(req) * eff;
    span = per_bit *
           ((req == i2cms_pkg::REQ_WRITE || req == i2cms_pkg::REQ_READ) ? 8 : 1);
    for (int k = 0; k < span; k++) begin
      t.cmd_valid = (k == 0) ? 1'b1 : ($urandom_range(99) < noise_pct);
      t.req_type = (k == 0) ? req : 3'($urandom_range(7));
      t.tx_byte = (k == 0) ? txb : 8'($urandom);
      t.sda_in = 1'($urandom_range(1));
      s = k / per_bit;
      if ((req == i2cms_pkg::REQ_WACK || req == i2cms_pkg::REQ_READ) &&
          (k % per_bit) == 2 * eff - 1)
        t.sda_in = sda_pat[7 - s];
      pending_ticks.push_back(t);
    end
    ticks_queued += span;
    cmds_issued++;
  endtask

  // idle ticks; some carry the unused command code
  task automatic push_gap(input int n, input int bad_pct);
    i2cms_pkg::in_item_t t;
    for (int k = 0; k < n; k++) begin
      t.cmd_valid = ($urandom_range(99) < bad_pct);
      t.req_type = t.cmd_valid ? i2cms_pkg::REQ_NONE : 3'($urandom_range(7));
      t.tx_byte = 8'($urandom);
      t.sda_in = 1'($urandom_range(1));
      pending_ticks.push_back(t);
    end
    ticks_queued += n;
  endtask

  // random commands with random content and gaps, often back to back
  task automatic push_random_commands(input int n);
    for (int i = 0; i < n; i++) begin
      push_command(3'($urandom_range(6)), 8'($urandom), 8'($urandom), 30);
      push_gap(($urandom_range(99) < 40) ? 0 : $urandom_range(4, 1), 25);
    end
  endtask

  // wait until every tick is sent and every line state seen, then settle
  task automatic wait_drained();
    while (ticks_taken != ticks_queued || expected_lines.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // phase length write, only while the sequencer is idle
  task automatic write_phase_len(input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    phase_len_cfg = v;
    cfg_writes++;
  endtask

  // driver: send queued ticks, idling at random
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_lines.push_back(line_sequencer_tick(in_data));
        ticks_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_ticks.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  i2cms_pkg::out_item_t want_line;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_lines.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result transaction: %p", out_data);
        end else begin
          want_line = expected_lines.pop_front();
          results_checked++;
          if (out_data.scl_out !== want_line.scl_out ||
              out_data.sda_out !== want_line.sda_out ||
              out_data.busy_res !== want_line.busy_res ||
              out_data.done_res !== want_line.done_res ||
              out_data.rx_byte !== want_line.rx_byte ||
              out_data.ack_received !== want_line.ack_received) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("tick %0d: expected scl=%b sda=%b busy=%b done=%b rx=%h ack=%b, got %s",
                       results_checked, want_line.scl_out, want_line.sda_out,
                       want_line.busy_res, want_line.done_res, want_line.rx_byte,
                       want_line.ack_received,
                       $sformatf("scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                                 out_data.scl_out, out_data.sda_out, out_data.busy_res,
                                 out_data.done_res, out_data.rx_byte,
                                 out_data.ack_received));
          end
        end
      end
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus sequence
  initial begin
    int unsigned idle_pct[4];
    int unsigned stall_pct[4];
    logic [15:0] len_plan[4];
    idle_pct = '{0, 46, 0, 12};
    stall_pct = '{0, 0, 46, 12};
    len_plan = '{16'd1, 16'd2, 16'd0, 16'd3};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // idle ticks at the reset phase length, unused code ignored
    push_gap(4, 50);
    wait_drained();

    // directed: every command, byte extremes, ack and nack, ignored codes
    write_phase_len(16'd0);
    push_command(i2cms_pkg::REQ_START, 8'h00, 8'h00, 50);
    push_command(i2cms_pkg::REQ_WRITE, 8'hFF, 8'h00, 50);
    push_command(i2cms_pkg::REQ_WACK, 8'h00, 8'h00, 50);
    push_command(i2cms_pkg::REQ_WRITE, 8'h01, 8'h00, 100);
    push_command(i2cms_pkg::REQ_WACK, 8'h00, 8'hFF, 50);
    push_command(i2cms_pkg::REQ_READ, 8'h00, 8'hFF, 50);
    push_command(i2cms_pkg::REQ_ACK, 8'h00, 8'h00, 50);
    push_command(i2cms_pkg::REQ_READ, 8'h00, 8'hA5, 50);
    push_command(i2cms_pkg::REQ_NACK, 8'h00, 8'h00, 50);
    push_command(i2cms_pkg::REQ_STOP, 8'h00, 8'h00, 50);
    push_gap(3, 100);
    // read after stop and an idle gap keeps sda released
    push_command(i2cms_pkg::REQ_READ, 8'h00, 8'h3C, 50);
    push_command(i2cms_pkg::REQ_START, 8'h00, 8'h00, 50);
    push_command(i2cms_pkg::REQ_STOP, 8'h00, 8'h00, 50);
    wait_drained();

    // random commands under each idling pattern
    for (int m = 0; m < 4; m++) begin
      sender_idle_pct = idle_pct[m];
      sink_stall_pct = stall_pct[m];
      write_phase_len(len_plan[m]);
      push_random_commands(5);
      wait_drained();
    end

    // longer phases, one short command only
    sender_idle_pct = 0;
    sink_stall_pct = 0;
    write_phase_len(16'd12);
    push_command(i2cms_pkg::REQ_START, 8'($urandom), 8'($urandom), 50);
    wait_drained();

    $display("covered %0d commands in %0d bus ticks, %0d results checked",
             cmds_issued, ticks_taken, results_checked);
    $display("phase length set %0d times, from 0 up to 12, under four idling patterns",
             cfg_writes);
    if (mismatch_count == 0 && expected_lines.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
